@@ hw/rtl/trs_pkg.sv @@
package trs_pkg;

    localparam int DATA_W      = 32;
    localparam int CORDIC_W    = 34;
    localparam int ATAN_N      = 24;
    localparam int ITER_DEF    = 18;
    localparam int TURN_Q16    = 23592960;
    localparam int QUARTER_Q16 = 5898240;
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef logic signed [CORDIC_W-1:0] t_cval;

    // arctangent of 2^-i in q30
    function automatic t_cval atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_q30 = 34'sh03243F6A8;
            5'd1:    atan_q30 = 34'sh01DAC6705;
            5'd2:    atan_q30 = 34'sh00FADBAFC;
            5'd3:    atan_q30 = 34'sh007F56EA6;
            5'd4:    atan_q30 = 34'sh003FEAB76;
            5'd5:    atan_q30 = 34'sh001FFD55B;
            5'd6:    atan_q30 = 34'sh000FFFAAA;
            5'd7:    atan_q30 = 34'sh0007FFF55;
            5'd8:    atan_q30 = 34'sh0003FFFEA;
            5'd9:    atan_q30 = 34'sh0001FFFFD;
            5'd10:   atan_q30 = 34'sh0000FFFFF;
            5'd11:   atan_q30 = 34'sh00007FFFF;
            5'd12:   atan_q30 = 34'sh00003FFFF;
            5'd13:   atan_q30 = 34'sh00001FFFF;
            5'd14:   atan_q30 = 34'sh00000FFFF;
            5'd15:   atan_q30 = 34'sh000007FFF;
            5'd16:   atan_q30 = 34'sh000003FFF;
            5'd17:   atan_q30 = 34'sh000001FFF;
            5'd18:   atan_q30 = 34'sh000000FFF;
            5'd19:   atan_q30 = 34'sh0000007FF;
            5'd20:   atan_q30 = 34'sh0000003FF;
            5'd21:   atan_q30 = 34'sh0000001FF;
            5'd22:   atan_q30 = 34'sh0000000FF;
            5'd23:   atan_q30 = 34'sh00000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    // q30 product rounded half up, floor shift
    function automatic t_cval mul_q30(input t_cval a, input t_cval b);
        logic signed [2*CORDIC_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        mul_q30 = CORDIC_W'(p >>> 30);
    endfunction

    // q30 rotation times q16.16 scale, saturated
    function automatic logic signed [DATA_W-1:0] scale_sat(input t_cval r,
                                                          input logic signed [DATA_W-1:0] s);
        logic signed [CORDIC_W+DATA_W-1:0] p;
        logic signed [CORDIC_W+DATA_W-1:0] q;
        p = r * s + (66'sd1 <<< 29);
        q = p >>> 30;
        if (q > 66'sd2147483647)       scale_sat = 32'sh7FFFFFFF;
        else if (q < -66'sd2147483648) scale_sat = 32'sh80000000;
        else                           scale_sat = q[DATA_W-1:0];
    endfunction

endpackage

@@ hw/rtl/trs_sincos.sv @@
module trs_sincos import trs_pkg::*; #(
    parameter int ITERS = ITER_DEF
) (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_angle,
    output t_cval                    o_cos,
    output t_cval                    o_sin
);
    localparam int N = (ITERS > ATAN_N) ? ATAN_N : ITERS;

    // stage a: wrap to one turn, a turn is 45 * 2^19
    // upper bits offset to unsigned, 4140 is a multiple of 45
    logic [13:0] n_hi;
    logic [27:0] n_prod;
    logic [7:0]  n_div;
    logic [5:0]  n_mod;
    logic [24:0] r_wrap;
    always_comb begin
        n_hi   = {1'b0, ~i_angle[DATA_W-1], i_angle[DATA_W-2:19]} + 14'd44;
        n_prod = {14'd0, n_hi} * 28'd23302;
        n_div  = n_prod[27:20];
        n_mod  = 6'(n_hi - {6'd0, n_div} * 14'd45);
    end
    always_ff @(posedge i_clk) begin
        r_wrap <= {n_mod, i_angle[18:0]};
    end

    // stage b: quadrant split and degree to radian
    logic [1:0]  n_quad;
    logic [22:0] n_rem;
    always_comb begin
        n_quad = 2'd0;
        n_rem  = r_wrap[22:0];
        if (r_wrap >= 25'd17694720) begin
            n_quad = 2'd3; n_rem = 23'(r_wrap - 25'd17694720);
        end else if (r_wrap >= 25'd11796480) begin
            n_quad = 2'd2; n_rem = 23'(r_wrap - 25'd11796480);
        end else if (r_wrap >= 25'd5898240) begin
            n_quad = 2'd1; n_rem = 23'(r_wrap - 25'd5898240);
        end
    end

    // cordic stages, one iteration per register
    t_cval      r_x [0:N];
    t_cval      r_y [0:N];
    t_cval      r_z [0:N];
    logic [1:0] r_q [0:N];
    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_q[0] <= n_quad;
        r_z[0] <= CORDIC_W'(({27'd0, n_rem} * {23'd0, DEG2RAD_Q32} + 50'd131072) >> 18);
    end
    for (genvar g = 0; g < N; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (r_z[g] >= 0) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - atan_q30(5'(g));
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + atan_q30(5'(g));
            end
            r_q[g+1] <= r_q[g];
        end
    end

    // quadrant fold
    always_ff @(posedge i_clk) begin
        case (r_q[N])
            2'd0:    begin o_cos <= r_x[N];  o_sin <= r_y[N];  end
            2'd1:    begin o_cos <= -r_y[N]; o_sin <= r_x[N];  end
            2'd2:    begin o_cos <= -r_x[N]; o_sin <= -r_y[N]; end
            default: begin o_cos <= r_y[N];  o_sin <= -r_x[N]; end
        endcase
    end
endmodule

@@ hw/rtl/trs_model_matrix_builder_unit.sv @@
// channel  | ports                          | direction
// request  | i_start, o_busy, pos/angle/scale | in, o_busy out
// result   | o_valid, o_m00..o_m23          | out
// a request enters every cycle; o_busy is always low
// the cordic depth is TRIG_ITERATIONS iterations, capped at 24
// reset (i_rst_n low, synchronous) clears the valid pipeline only
// results are strobed one cycle by o_valid and cannot be stalled
module trs_model_matrix_builder_unit import trs_pkg::*; #(
    parameter int TRIG_ITERATIONS = ITER_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_pos_x, i_pos_y, i_pos_z,
    input  logic signed [DATA_W-1:0] i_angle_x, i_angle_y, i_angle_z,
    input  logic signed [DATA_W-1:0] i_scale_x, i_scale_y, i_scale_z,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_m00, o_m01, o_m02, o_m03,
    output logic signed [DATA_W-1:0] o_m10, o_m11, o_m12, o_m13,
    output logic signed [DATA_W-1:0] o_m20, o_m21, o_m22, o_m23
);
    localparam int NI  = (TRIG_ITERATIONS > ATAN_N) ? ATAN_N : TRIG_ITERATIONS;
    localparam int TRG = NI + 3;
    localparam int LAT = TRG + 4;

    assign o_busy = 1'b0;

    t_cval cx, sx, cy, sy, cz, sz;
    trs_sincos #(.ITERS(TRIG_ITERATIONS)) u_x (.i_clk, .i_angle(i_angle_x),
                                               .o_cos(cx), .o_sin(sx));
    trs_sincos #(.ITERS(TRIG_ITERATIONS)) u_y (.i_clk, .i_angle(i_angle_y),
                                               .o_cos(cy), .o_sin(sy));
    trs_sincos #(.ITERS(TRIG_ITERATIONS)) u_z (.i_clk, .i_angle(i_angle_z),
                                               .o_cos(cz), .o_sin(sz));

    // valid and side payload delay lines
    logic                     r_vld [0:LAT];
    logic signed [DATA_W-1:0] r_pos [0:LAT-1][0:2];
    logic signed [DATA_W-1:0] r_scl [0:LAT-2][0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
            for (int k = 1; k <= LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_pos[0][0] <= i_pos_x; r_pos[0][1] <= i_pos_y; r_pos[0][2] <= i_pos_z;
        r_scl[0][0] <= i_scale_x; r_scl[0][1] <= i_scale_y; r_scl[0][2] <= i_scale_z;
        for (int k = 1; k < LAT; k++)
            for (int j = 0; j < 3; j++) r_pos[k][j] <= r_pos[k-1][j];
        for (int k = 1; k < LAT-1; k++)
            for (int j = 0; j < 3; j++) r_scl[k][j] <= r_scl[k-1][j];
    end

    // stage 1: pair products
    t_cval r_t, r_u, r_czs, r_szs, r_cy1, r_sy1, r_cx1, r_sx1;
    t_cval r_00a, r_10a, r_21a, r_22a;
    always_ff @(posedge i_clk) begin
        r_t  <= mul_q30(sy, sx); r_u <= mul_q30(sy, cx);
        r_00a <= mul_q30(cz, cy); r_10a <= mul_q30(sz, cy);
        r_21a <= mul_q30(cy, sx); r_22a <= mul_q30(cy, cx);
        r_czs <= cz; r_szs <= sz; r_cy1 <= cy; r_sy1 <= sy; r_cx1 <= cx; r_sx1 <= sx;
    end

    // stage 2: remaining products
    t_cval r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7, r_p8;
    t_cval r_00b, r_10b, r_20b, r_21b, r_22b;
    always_ff @(posedge i_clk) begin
        r_p1 <= mul_q30(r_czs, r_t); r_p2 <= mul_q30(r_szs, r_cx1);
        r_p3 <= mul_q30(r_czs, r_u); r_p4 <= mul_q30(r_szs, r_sx1);
        r_p5 <= mul_q30(r_szs, r_t); r_p6 <= mul_q30(r_czs, r_cx1);
        r_p7 <= mul_q30(r_szs, r_u); r_p8 <= mul_q30(r_czs, r_sx1);
        r_00b <= r_00a; r_10b <= r_10a; r_20b <= r_sy1; r_21b <= r_21a; r_22b <= r_22a;
    end

    // stage 3: rotation sums
    t_cval r_rot [0:2][0:2];
    always_ff @(posedge i_clk) begin
        r_rot[0][0] <= r_00b;
        r_rot[0][1] <= -r_p1 - r_p2;
        r_rot[0][2] <= -r_p3 + r_p4;
        r_rot[1][0] <= r_10b;
        r_rot[1][1] <= -r_p5 + r_p6;
        r_rot[1][2] <= -r_p7 - r_p8;
        r_rot[2][0] <= r_20b;
        r_rot[2][1] <= r_21b;
        r_rot[2][2] <= r_22b;
    end

    // stage 4: scale and saturate
    logic signed [DATA_W-1:0] r_m [0:2][0:2];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r_m[i][j] <= scale_sat(r_rot[i][j], r_scl[LAT-2][j]);
    end

    // output register
    always_ff @(posedge i_clk) begin
        o_m00 <= r_m[0][0]; o_m01 <= r_m[0][1]; o_m02 <= r_m[0][2]; o_m03 <= r_pos[LAT-1][0];
        o_m10 <= r_m[1][0]; o_m11 <= r_m[1][1]; o_m12 <= r_m[1][2]; o_m13 <= r_pos[LAT-1][1];
        o_m20 <= r_m[2][0]; o_m21 <= r_m[2][1]; o_m22 <= r_m[2][2]; o_m23 <= r_pos[LAT-1][2];
    end
    assign o_valid = r_vld[LAT];

    // every request accepted into the valid line must come out as an o_valid strobe
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(LAT) o_valid) else $error("lost request");
    a_busy: assert property (@(posedge i_clk) !o_busy) else $error("busy raised");
    // no result strobe right after a reset cycle
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_vld_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid)) else $error("valid unknown");
endmodule
